FILE: hw/rtl/ktb_pkg.sv
// ----------------------------------------------------------------------------
// ktb_pkg
// Shared types and constants for the keyed token-bucket limiter.
// ----------------------------------------------------------------------------
package ktb_pkg;

  // opcodes of an input transaction
  typedef enum logic [1:0] {
    OP_ACQ_DEFAULT = 2'd0,
    OP_ACQ_KEYED   = 2'd1,
    OP_STATUS      = 2'd2,
    OP_REMOVE      = 2'd3
  } ktb_op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_REFILL_RATE = 2'd0;
  localparam logic [1:0] CFG_BURST_SIZE  = 2'd1;
  localparam logic [1:0] CFG_MIN_REFILL  = 2'd2;

  localparam logic [31:0] RESET_REFILL_RATE = 32'd1678;
  localparam logic [31:0] RESET_BURST_SIZE  = 32'd256000;
  localparam logic [31:0] RESET_MIN_REFILL  = 32'd1;

  localparam int TOK_W  = 32;
  localparam int TICK_W = 48;
  localparam int KEY_W  = 64;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REFILL,
    S_ACQ,
    S_FIN
  } ktb_state_t;

  typedef enum logic [2:0] {
    R_IDLE,
    R_MUL_LO,
    R_MUL_HI,
    R_SUM,
    R_APPLY,
    R_DONE
  } ktb_rf_state_t;

  // bucket handed to the refill unit
  typedef struct packed {
    logic [TOK_W-1:0]  tokens;
    logic [TICK_W-1:0] last_refill;
    logic [TICK_W-1:0] now_ticks;
  } ktb_refill_req_t;

  // refill configuration; the user must keep it stable while a transaction is in flight, the block does not enforce it
  typedef struct packed {
    logic [31:0] refill_rate;
    logic [31:0] burst_size;
    logic [31:0] min_refill_ticks;
  } ktb_refill_cfg_t;

  // refill result back to the controller
  typedef struct packed {
    logic             done;
    logic             refilled;
    logic [TOK_W-1:0] tokens;
  } ktb_refill_rsp_t;

  // one keyed bucket as stored in the table memory
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TOK_W-1:0]  tokens;
    logic [TICK_W-1:0] last_refill;
  } ktb_entry_t;

endpackage

FILE: hw/rtl/ktb_refill_unit.sv
// ----------------------------------------------------------------------------
// ktb_refill_unit
// Multi-cycle bucket refill: elapsed ticks times rate in two partial
// products, then add, cap at burst size and gate by the minimum interval.
// ----------------------------------------------------------------------------
module ktb_refill_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  ktb_pkg::ktb_refill_req_t req,
  input  ktb_pkg::ktb_refill_cfg_t cfg,
  output ktb_pkg::ktb_refill_rsp_t rsp
);
  import ktb_pkg::*;

  ktb_rf_state_t     state, state_next;
  ktb_refill_req_t   req_q;
  logic [TICK_W-1:0] elapsed;
  logic              eligible;
  logic [55:0]       p_lo;
  logic [55:0]       p_hi;
  logic [79:0]       prod;
  logic [TOK_W-1:0]  tokens_out;
  logic              refilled;
  logic [32:0]       sum;
  logic              over;
  logic [TOK_W-1:0]  capped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      R_IDLE:   if (go) state_next = R_MUL_LO;
      R_MUL_LO: state_next = R_MUL_HI;
      R_MUL_HI: state_next = R_SUM;
      R_SUM:    state_next = R_APPLY;
      R_APPLY:  state_next = R_DONE;
      R_DONE:   state_next = R_IDLE;
      default:  state_next = R_IDLE;
    endcase
  end

  // anything at or above 2^48 in the product saturates the add
  always_comb begin
    sum    = {1'b0, req_q.tokens} + {1'b0, prod[47:16]};
    over   = (|prod[79:48]) || (sum > {1'b0, cfg.burst_size});
    capped = over ? cfg.burst_size : sum[TOK_W-1:0];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      R_IDLE: begin
        if (go) begin
          req_q   <= req;
          elapsed <= req.now_ticks - req.last_refill;
        end
      end
      R_MUL_LO: begin
        p_lo     <= {32'd0, elapsed[23:0]} * {24'd0, cfg.refill_rate};
        eligible <= elapsed >= {16'd0, cfg.min_refill_ticks};
      end
      R_MUL_HI: p_hi <= {32'd0, elapsed[47:24]} * {24'd0, cfg.refill_rate};
      R_SUM:    prod <= {p_hi, 24'd0} + {24'd0, p_lo};
      R_APPLY: begin
        tokens_out <= eligible ? capped : req_q.tokens;
        refilled   <= eligible;
      end
      R_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    rsp.done     = (state == R_DONE);
    rsp.refilled = refilled;
    rsp.tokens   = tokens_out;
  end

endmodule

FILE: hw/rtl/keyed_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// keyed_token_bucket_limiter
// Token-bucket limiter with a default bucket and a table of keyed buckets.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// result appears for one cycle with done high and must be captured then.
// A keyed transaction scans the table memory through the single read port,
// one entry per cycle, until the key matches or all entries are read. After
// reset the table is cleared one entry per cycle with busy high.
// Configuration is written through cfg_we, cfg_index, cfg_data.
module keyed_token_bucket_limiter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [63:0] key_id,
  input  logic [31:0] request_tokens,
  input  logic [47:0] now_ticks,
  output logic        done,
  output logic        granted,
  output logic        key_found,
  output logic [31:0] tokens_left,
  output logic [31:0] burst_used,
  output logic        table_full,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ktb_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] SCAN_END = CW'(TABLE_ENTRIES);

  ktb_state_t state, state_next;

  // configuration
  logic [31:0] refill_rate;
  logic [31:0] burst_size;
  logic [31:0] min_refill_ticks;

  // default bucket
  logic [TOK_W-1:0]  default_tokens;
  logic [TICK_W-1:0] default_last;

  // transaction working set
  ktb_op_t           w_op;
  logic [KEY_W-1:0]  w_key;
  logic [TOK_W-1:0]  w_req;
  logic [TICK_W-1:0] w_now;
  logic [TOK_W-1:0]  w_tok;
  logic [TICK_W-1:0] w_last;
  logic [AW-1:0]     w_idx;
  logic              w_has_idx;
  logic              w_found;
  logic              w_full;
  logic              w_granted;
  logic              w_report;

  // table memory and scan
  ktb_entry_t    mem [TABLE_ENTRIES];
  ktb_entry_t    rdata;
  ktb_entry_t    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic          mem_we;
  logic [AW-1:0] clr_cnt;
  logic [CW-1:0] scan_cnt;
  logic          scan_issue;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          match;
  logic          free_any;
  logic [AW-1:0] free_sel;
  logic          scan_end;
  logic          need_refill;

  // refill unit
  logic            rf_go;
  ktb_refill_req_t rf_req;
  ktb_refill_cfg_t rf_cfg;
  ktb_refill_rsp_t rf_rsp;

  logic [TOK_W-1:0] used_val;

  ktb_refill_unit u_refill (
    .clk (clk),
    .rst (rst),
    .go  (rf_go),
    .req (rf_req),
    .cfg (rf_cfg),
    .rsp (rf_rsp)
  );

  always_comb begin
    rf_req.tokens           = w_tok;
    rf_req.last_refill      = w_last;
    rf_req.now_ticks        = w_now;
    rf_cfg.refill_rate      = refill_rate;
    rf_cfg.burst_size       = burst_size;
    rf_cfg.min_refill_ticks = min_refill_ticks;
  end

  // scan decode
  always_comb begin
    scan_issue  = scan_cnt < SCAN_END;
    match       = rd_pend && rdata.valid && (rdata.key == w_key);
    free_any    = free_found || (rd_pend && !rdata.valid);
    free_sel    = free_found ? free_idx : rd_idx;
    scan_end    = rd_pend && (match || rd_idx == LAST_IDX);
    need_refill = ((w_op == OP_ACQ_KEYED) && (match || free_any)) ||
                  ((w_op == OP_STATUS) && match);
  end

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_cnt == LAST_IDX) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          state_next = (ktb_op_t'(opcode) == OP_ACQ_DEFAULT) ? S_REFILL : S_SCAN;
        end
      end
      S_SCAN:   if (scan_end) state_next = need_refill ? S_REFILL : S_FIN;
      S_REFILL: if (rf_rsp.done) state_next = S_ACQ;
      S_ACQ:    state_next = S_FIN;
      S_FIN:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    busy      = (state != S_IDLE);
    mem_raddr = scan_cnt[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = w_idx;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      S_FIN: begin
        mem_we                = (w_op != OP_ACQ_DEFAULT) && w_has_idx;
        mem_wdata.valid       = (w_op != OP_REMOVE);
        mem_wdata.key         = w_key;
        mem_wdata.tokens      = w_tok;
        mem_wdata.last_refill = w_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      scan_cnt   <= '0;
      rd_pend    <= 1'b0;
      free_found <= 1'b0;
      rf_go      <= 1'b0;
      done       <= 1'b0;
    end else begin
      rf_go   <= (state != S_REFILL) && (state_next == S_REFILL);
      done    <= (state == S_FIN);
      rd_pend <= (state == S_SCAN) && scan_issue;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_IDLE) begin
        scan_cnt   <= '0;
        free_found <= 1'b0;
      end else if (state == S_SCAN) begin
        if (scan_issue) begin
          scan_cnt <= scan_cnt + 1'b1;
        end
        if (rd_pend && !rdata.valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  // configuration and default bucket
  always_ff @(posedge clk) begin
    if (rst) begin
      refill_rate      <= RESET_REFILL_RATE;
      burst_size       <= RESET_BURST_SIZE;
      min_refill_ticks <= RESET_MIN_REFILL;
      default_tokens   <= RESET_BURST_SIZE;
      default_last     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_REFILL_RATE: refill_rate <= cfg_data;
          CFG_BURST_SIZE: begin
            burst_size <= cfg_data;
            if (default_tokens > cfg_data) begin
              default_tokens <= cfg_data;
            end
          end
          CFG_MIN_REFILL: min_refill_ticks <= cfg_data;
          default: ;
        endcase
      end else if (state == S_FIN && w_op == OP_ACQ_DEFAULT) begin
        default_tokens <= w_tok;
        default_last   <= w_last;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          w_op      <= ktb_op_t'(opcode);
          w_key     <= key_id;
          w_req     <= request_tokens;
          w_now     <= now_ticks;
          w_tok     <= default_tokens;
          w_last    <= default_last;
          w_has_idx <= 1'b0;
          w_found   <= 1'b0;
          w_full    <= 1'b0;
          w_granted <= 1'b0;
          w_report  <= (ktb_op_t'(opcode) == OP_ACQ_DEFAULT);
        end
      end
      S_SCAN: begin
        if (rd_pend && !rdata.valid && !free_found) begin
          free_idx <= rd_idx;
        end
        if (scan_end) begin
          w_found  <= match;
          w_report <= need_refill;
          if (match) begin
            w_has_idx <= 1'b1;
            w_idx     <= rd_idx;
            w_tok     <= rdata.tokens;
            w_last    <= rdata.last_refill;
          end else if (w_op == OP_ACQ_KEYED) begin
            // new key takes a full bucket in the lowest free slot
            if (free_any) begin
              w_has_idx <= 1'b1;
              w_idx     <= free_sel;
              w_tok     <= burst_size;
              w_last    <= w_now;
            end else begin
              w_full <= 1'b1;
            end
          end
        end
      end
      S_REFILL: begin
        if (rf_rsp.done) begin
          w_tok <= rf_rsp.tokens;
          if (rf_rsp.refilled) begin
            w_last <= w_now;
          end
        end
      end
      S_ACQ: begin
        if ((w_op == OP_ACQ_DEFAULT || w_op == OP_ACQ_KEYED) && w_tok >= w_req) begin
          w_granted <= 1'b1;
          w_tok     <= w_tok - w_req;
        end
      end
      default: ;
    endcase
    if (state == S_SCAN) begin
      rd_idx <= scan_cnt[AW-1:0];
    end
  end

  // result registers
  always_comb begin
    used_val = (w_tok > burst_size) ? '0 : burst_size - w_tok;
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      granted     <= w_granted;
      key_found   <= w_found;
      table_full  <= w_full;
      tokens_left <= w_report ? w_tok : '0;
      burst_used  <= w_report ? used_val : '0;
    end
  end

endmodule
